/* rtl/ssp_pkg.sv */
// shared types, constants and helpers for the servo sweep pwm generator
`timescale 1ns / 1ps

package ssp_pkg;

    // field and register widths
    localparam int PERIOD_W   = 16;
    localparam int PULSE_W    = 12;
    localparam int HOLD_W     = 24;
    localparam int LEVEL_W    = 8;
    localparam int ANGLE_W    = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // sweep geometry
    localparam int STEP_DEGREES = 30;
    localparam int MAX_LEVEL    = 6;
    localparam int MAX_ANGLE    = 180;

    // pulse step per degree: signed, |step| <= 4095 / 180
    localparam int STEP_W = 6;
    // high time min_pulse + step * angle, signed
    localparam int HIGH_W = 14;

    // divide by 180 through a reciprocal: exact for magnitudes below 4096
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / MAX_ANGLE + 1;
    localparam int RECIP_PROD_W = PULSE_W + 13;
    localparam int QUOT_W = STEP_W - 1;

    // register reset values
    localparam int PERIOD_RST_I    = 20000;
    localparam int MIN_PULSE_RST_I = 544;
    localparam int MAX_PULSE_RST_I = 2440;
    localparam int HOLD_RST_I      = 3000000;
    localparam int STEP_RST_I      = (MAX_PULSE_RST_I - MIN_PULSE_RST_I) / MAX_ANGLE;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST    = PERIOD_W'(PERIOD_RST_I);
    localparam logic [PULSE_W-1:0]   MIN_PULSE_RST = PULSE_W'(MIN_PULSE_RST_I);
    localparam logic [PULSE_W-1:0]   MAX_PULSE_RST = PULSE_W'(MAX_PULSE_RST_I);
    localparam logic [HOLD_W-1:0]    HOLD_RST      = HOLD_W'(HOLD_RST_I);
    localparam logic signed [STEP_W-1:0] STEP_RST  = STEP_W'(STEP_RST_I);

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD    = 2'd0,
        REG_MIN_PULSE = 2'd1,
        REG_MAX_PULSE = 2'd2,
        REG_HOLD      = 2'd3
    } cfg_reg_t;

    // configuration as seen by the sweep engine
    typedef struct packed {
        logic [PERIOD_W-1:0]       period_us;
        logic [PULSE_W-1:0]        min_pulse_us;
        logic [HOLD_W-1:0]         hold_us;
        logic signed [STEP_W-1:0]  step;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic               pin_level;
        logic               busy_res;
        logic [ANGLE_W-1:0] angle_now;
    } res_t;

    // target angle for a command level, clipped at full travel
    function automatic logic [ANGLE_W-1:0] target_of(input logic [LEVEL_W-1:0] lvl);
        logic [15:0] prod;
        prod = 16'(STEP_DEGREES) * 16'(lvl);
        return (prod > 16'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE) : prod[ANGLE_W-1:0];
    endfunction

endpackage

/* rtl/ssp_cfg.sv */
// configuration registers and the registered pulse step per degree
`timescale 1ns / 1ps

module ssp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
    output ssp_pkg::cfg_t                cfg
);
    import ssp_pkg::*;

    logic [PERIOD_W-1:0]      period_reg;
    logic [PULSE_W-1:0]       min_pulse_reg;
    logic [PULSE_W-1:0]       max_pulse_reg;
    logic [HOLD_W-1:0]        hold_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [STEP_W-1:0] step_next;

    logic signed [PULSE_W:0]   diff;
    logic [PULSE_W-1:0]        mag;
    logic [RECIP_PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]         quot;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RST;
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            hold_reg      <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PERIOD:    period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_MIN_PULSE: min_pulse_reg <= cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE: max_pulse_reg <= cfg_data[PULSE_W-1:0];
                REG_HOLD:      hold_reg      <= cfg_data[HOLD_W-1:0];
                default:       period_reg    <= period_reg;
            endcase
        end
    end

    // (max - min) / 180, truncated toward zero
    always_comb
    begin
        diff = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});
        mag  = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
        prod = RECIP_PROD_W'(mag) * RECIP_PROD_W'(RECIP_MUL);
        quot = prod[RECIP_SHIFT +: QUOT_W];
        step_next = diff[PULSE_W] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // step is registered from the pulse registers and follows them in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RST;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign cfg.period_us    = period_reg;
    assign cfg.min_pulse_us = min_pulse_reg;
    assign cfg.hold_us      = hold_reg;
    assign cfg.step         = step_reg;

endmodule

/* rtl/ssp_engine.sv */
// sweep state machine: phase, angle, period and hold counters, high time per angle
`timescale 1ns / 1ps

module ssp_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssp_pkg::cfg_t                cfg,
    input  logic                         advance,
    input  logic                         req_type,
    input  logic [ssp_pkg::LEVEL_W-1:0]  level,
    output ssp_pkg::res_t                res
);
    import ssp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_HOLD = 2'd2,
        PH_DOWN = 2'd3
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [ANGLE_W-1:0]        angle_reg, angle_next;
    logic [ANGLE_W-1:0]        target_reg, target_next;
    logic [PERIOD_W-1:0]       pcount_reg, pcount_next;
    logic [HOLD_W-1:0]         hcount_reg, hcount_next;

    logic [PERIOD_W:0]         pcount_inc;
    logic [HOLD_W-1:0]         hcount_inc;
    logic signed [HIGH_W-1:0]  step_ext;
    logic signed [HIGH_W-1:0]  angle_ext;
    logic signed [HIGH_W-1:0]  high_now;
    logic                      driving;

    // next state for the item in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        angle_next  = angle_reg;
        target_next = target_reg;
        pcount_next = pcount_reg;
        hcount_next = hcount_reg;
        pcount_inc  = {1'b0, pcount_reg} + (PERIOD_W+1)'(1);
        hcount_inc  = hcount_reg + HOLD_W'(1);

        if (req_type == REQ_CMD)
        begin
            // a valid command only starts a sweep from idle
            if (phase_reg == PH_IDLE && (level inside {[1:MAX_LEVEL]}))
            begin
                target_next = target_of(level);
                angle_next  = '0;
                pcount_next = '0;
                hcount_next = '0;
                phase_next  = PH_UP;
            end
        end
        else
        begin
            case (phase_reg)
                PH_UP, PH_DOWN:
                begin
                    if (pcount_inc >= {1'b0, cfg.period_us})
                    begin
                        // end of one pwm period
                        pcount_next = '0;
                        if (phase_reg == PH_UP)
                        begin
                            if (angle_reg >= target_reg)
                            begin
                                hcount_next = '0;
                                phase_next  = (cfg.hold_us == '0) ? PH_DOWN : PH_HOLD;
                            end
                            else
                            begin
                                angle_next = angle_reg + ANGLE_W'(1);
                            end
                        end
                        else if (angle_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            angle_next = angle_reg - ANGLE_W'(1);
                        end
                    end
                    else
                    begin
                        pcount_next = pcount_inc[PERIOD_W-1:0];
                    end
                end
                PH_HOLD:
                begin
                    hcount_next = hcount_inc;
                    if (hcount_inc >= cfg.hold_us)
                    begin
                        pcount_next = '0;
                        phase_next  = PH_DOWN;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result from the state after this item; high time from the current registers,
    // a negative high time keeps the pin low
    always_comb
    begin
        step_ext      = HIGH_W'(cfg.step);
        angle_ext     = $signed({{(HIGH_W-ANGLE_W){1'b0}}, angle_next});
        high_now      = $signed({2'b00, cfg.min_pulse_us}) + step_ext * angle_ext;
        driving       = (phase_next == PH_UP) || (phase_next == PH_DOWN);
        res.pin_level = driving && !high_now[HIGH_W-1]
                        && (pcount_next < PERIOD_W'(high_now[HIGH_W-2:0]));
        res.busy_res  = (phase_next != PH_IDLE);
        res.angle_now = angle_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            angle_reg  <= '0;
            target_reg <= '0;
            pcount_reg <= '0;
            hcount_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            angle_reg  <= angle_next;
            target_reg <= target_next;
            pcount_reg <= pcount_next;
            hcount_reg <= hcount_next;
        end
    end

endmodule

/* rtl/servo_sweep_pwm_generator.sv */
// top level of the servo sweep pwm generator: handshake, input and result registers
`timescale 1ns / 1ps

// Each input item is either a one-microsecond tick or a sweep command. An item
// is taken into an input register, the sweep state is updated from it once the
// result register can take its result, and that result lands in the output
// register, so each item passes the input register and then the result register.
// One item is accepted every cycle as long as results are drained, since the
// whole state update (period and hold counters, angle, high time for the angle)
// is one combinational step; a waiting result that is not taken holds the item
// in the input register and blocks the next one. The pulse step per degree is
// derived from the pulse registers through a registered divide-by-180, so it
// follows a configuration write in the next cycle.

module servo_sweep_pwm_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [ssp_pkg::LEVEL_W-1:0]    level,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           pin_level,
    output logic                           busy_res,
    output logic [ssp_pkg::ANGLE_W-1:0]    angle_now
);
    import ssp_pkg::*;

    cfg_t               cfg;
    res_t               res;

    logic               stage_valid_reg;
    logic               req_type_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    logic               advance;

    // the item in the input register moves on when the result register frees up
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    ssp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssp_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .advance  (advance),
        .req_type (req_type_reg),
        .level    (level_reg),
        .res      (res)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            level_reg    <= level;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_level = out_reg.pin_level;
    assign busy_res  = out_reg.busy_res;
    assign angle_now = out_reg.angle_now;

endmodule

/* rtl/ssp_checker.sv */
// port-level checks for the servo sweep pwm generator, bound to the top level
`timescale 1ns / 1ps

module ssp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        pin_level,
    input logic                        busy_res,
    input logic [ssp_pkg::ANGLE_W-1:0] angle_now
);
    import ssp_pkg::*;

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_level)
            && $stable(busy_res) && $stable(angle_now))
        else $error("stalled result item changed");

    // the pin only drives during a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_level |-> busy_res)
        else $error("pin high while idle");

    // idle always sits at angle zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> angle_now == '0)
        else $error("idle with non-zero angle");

    // angle never goes past full travel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_now <= ANGLE_W'(MAX_ANGLE))
        else $error("angle beyond full travel");

endmodule

bind servo_sweep_pwm_generator ssp_checker u_ssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .angle_now (angle_now)
);

/* test/servo_sweep_pwm_generator_tb.sv */
// self-checking testbench for the servo sweep pwm generator
`timescale 1ns / 1ps

module servo_sweep_pwm_generator_tb;

    import ssp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int QUIET_ITEMS    = 300;

    // sweep phases of the predictor
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UP   = 2'd1,
        PH_HOLD = 2'd2,
        PH_DOWN = 2'd3
    } sweep_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [LEVEL_W-1:0]    level;
    logic                  out_valid;
    logic                  out_ready;
    logic                  pin_level;
    logic                  busy_res;
    logic [ANGLE_W-1:0]    angle_now;

    // predictor copy of the registers
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;
    logic [PULSE_W-1:0]  cfg_min    = MIN_PULSE_RST;
    logic [PULSE_W-1:0]  cfg_max    = MAX_PULSE_RST;
    logic [HOLD_W-1:0]   cfg_hold   = HOLD_RST;

    // predictor copy of the sweep state
    sweep_phase_t        sw_phase   = PH_IDLE;
    logic [ANGLE_W-1:0]  sw_angle   = '0;
    logic [ANGLE_W-1:0]  sw_target  = '0;
    logic [PERIOD_W-1:0] sw_pos     = '0;
    logic [HOLD_W-1:0]   sw_hold    = '0;

    res_t pending_pwm[$];
    int   errors       = 0;
    int   swept_items  = 0;
    int   stall_cycles = 0;
    bit   in_gaps      = 1'b1;
    bit   out_gaps     = 1'b1;

    servo_sweep_pwm_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .level     (level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pin_level (pin_level),
        .busy_res  (busy_res),
        .angle_now (angle_now)
    );

    // clock
    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // high time for an angle, clipped at zero
    function automatic int pulse_high(input logic [ANGLE_W-1:0] a);
        int step;
        int h;
        step = (int'(cfg_max) - int'(cfg_min)) / MAX_ANGLE;
        h = int'(cfg_min) + step * int'(a);
        return (h < 0) ? 0 : h;
    endfunction

    // one item through the sweep state, returning the result it causes
    function automatic res_t advance_sweep(input logic req, input logic [LEVEL_W-1:0] lvl);
        res_t r;
        int   next_pos;
        int   tgt;
        if (req == REQ_CMD) begin
            // only a valid level while idle starts a sweep
            if (sw_phase == PH_IDLE && lvl >= 1 && int'(lvl) <= MAX_LEVEL) begin
                tgt = STEP_DEGREES * int'(lvl);
                sw_target = ANGLE_W'((tgt > MAX_ANGLE) ? MAX_ANGLE : tgt);
                sw_angle  = '0;
                sw_pos    = '0;
                sw_hold   = '0;
                sw_phase  = PH_UP;
            end
        end else if (sw_phase == PH_UP || sw_phase == PH_DOWN) begin
            next_pos = int'(sw_pos) + 1;
            if (next_pos >= int'(cfg_period)) begin
                // end of one pwm period
                sw_pos = '0;
                if (sw_phase == PH_UP) begin
                    if (sw_angle >= sw_target) begin
                        sw_hold  = '0;
                        sw_phase = (cfg_hold == '0) ? PH_DOWN : PH_HOLD;
                    end else begin
                        sw_angle = sw_angle + 1'b1;
                    end
                end else if (sw_angle == '0) begin
                    sw_phase = PH_IDLE;
                end else begin
                    sw_angle = sw_angle - 1'b1;
                end
            end else begin
                sw_pos = PERIOD_W'(next_pos);
            end
        end else if (sw_phase == PH_HOLD) begin
            sw_hold = sw_hold + 1'b1;
            if (sw_hold >= cfg_hold) begin
                sw_pos   = '0;
                sw_phase = PH_DOWN;
            end
        end
        r.pin_level = (sw_phase == PH_UP || sw_phase == PH_DOWN) &&
                      (int'(sw_pos) < pulse_high(sw_angle));
        r.busy_res  = (sw_phase != PH_IDLE);
        r.angle_now = sw_angle;
        return r;
    endfunction

    // offer one item, with an optional idle burst in front of it
    task automatic send_item(input logic req, input logic [LEVEL_W-1:0] lvl);
        res_t r;
        logic was_busy;
        int   gap;
        if (in_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        req_type = req;
        level    = lvl;
        do @(posedge clk); while (!in_ready);
        was_busy = (sw_phase != PH_IDLE);
        r = advance_sweep(req, lvl);
        pending_pwm.push_back(r);
        if ((was_busy && req == REQ_TICK) || (!was_busy && r.busy_res))
            swept_items++;
    endtask

    // stop offering items and wait for every result to come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pwm.size() != 0) @(posedge clk);
    endtask

    // register write, mirrored into the predictor with the register widths
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_PERIOD:    cfg_period = value[PERIOD_W-1:0];
            REG_MIN_PULSE: cfg_min    = value[PULSE_W-1:0];
            REG_MAX_PULSE: cfg_max    = value[PULSE_W-1:0];
            REG_HOLD:      cfg_hold   = value[HOLD_W-1:0];
            default:       ;
        endcase
    endtask

    // all four registers, written while nothing is in flight
    task automatic set_config(input logic [PERIOD_W-1:0] period, input logic [PULSE_W-1:0] minp,
                              input logic [PULSE_W-1:0] maxp, input logic [HOLD_W-1:0] hold);
        logic [31:0] junk;
        junk = $urandom;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        // unused upper data bits carry random junk
        write_reg(REG_PERIOD,    {junk[7:0], period});
        write_reg(REG_MIN_PULSE, {junk[19:8], minp});
        write_reg(REG_MAX_PULSE, {junk[31:20], maxp});
        write_reg(REG_HOLD,      hold);
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // bad levels and ticks while idle leave the block idle
    task automatic test_ignored_commands();
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_CMD, 8'd0);
        send_item(REQ_CMD, LEVEL_W'(MAX_LEVEL + 1));
        send_item(REQ_CMD, 8'hFF);
        send_item(REQ_TICK, 8'd0);
    endtask

    // reset registers, then a period cut below the current position mid-sweep
    task automatic test_period_shrink();
        send_item(REQ_CMD, 8'd1);
        repeat (3) send_item(REQ_TICK, 8'd0);
        // high time now beyond the period, so the pin stays high
        set_config(16'd2, MIN_PULSE_RST, MAX_PULSE_RST, HOLD_RST);
        repeat (3) send_item(REQ_TICK, 8'hA5);
        // command while busy
        send_item(REQ_CMD, 8'd3);
    endtask

    // largest period and hold, pulse bounds at opposite ends
    task automatic test_register_extremes();
        set_config(16'hFFFF, 12'hFFF, 12'h000, 24'hFFFFFF);
        repeat (2) send_item(REQ_TICK, 8'h5A);
    endtask

    // zero period acts as one tick per period
    task automatic test_zero_period();
        set_config(16'd0, 12'd0, 12'hFFF, 24'd0);
        repeat (4) send_item(REQ_TICK, 8'd0);
    endtask

    // random settings, mostly well-formed sweeps with noise between them
    task automatic test_random_sweeps();
        int                  goal;
        int                  n;
        bit                  fast;
        logic [PERIOD_W-1:0] period;
        logic [PULSE_W-1:0]  minp;
        logic [PULSE_W-1:0]  maxp;
        logic [HOLD_W-1:0]   hold;
        int                  pick;
        logic [LEVEL_W-1:0]  lvl;
        goal = swept_items + RANDOM_ITEMS;
        while (swept_items < goal) begin
            if (swept_items >= goal - QUIET_ITEMS) begin
                in_gaps  = 1'b0;
                out_gaps = 1'b0;
            end else begin
                in_gaps  = ($urandom_range(0, 3) != 0);
                out_gaps = ($urandom_range(0, 3) != 0);
            end
            fast = $urandom_range(0, 1);
            if (fast) begin
                period = PERIOD_W'($urandom_range(0, 3));
                minp   = PULSE_W'($urandom_range(0, 4095));
                maxp   = PULSE_W'($urandom_range(0, 4095));
            end else begin
                // periods long enough for the pin to toggle
                period = PERIOD_W'($urandom_range(4, 40));
                minp   = PULSE_W'($urandom_range(0, int'(period) + 4));
                pick   = $urandom_range(0, 2);
                if (pick == 0) begin
                    n    = int'(minp) + MAX_ANGLE * $urandom_range(0, 2);
                    maxp = PULSE_W'((n > 4095) ? 4095 : n);
                end else if (pick == 1) begin
                    maxp = PULSE_W'($urandom_range(0, int'(minp)));
                end else begin
                    maxp = PULSE_W'($urandom_range(0, 4095));
                end
            end
            case ($urandom_range(0, 3))
                0:       hold = '0;
                1:       hold = HOLD_W'($urandom_range(1, 8));
                2:       hold = HOLD_W'($urandom_range(9, 40));
                default: hold = HOLD_W'($urandom_range(0, 3));
            endcase
            set_config(period, minp, maxp, hold);
            n = $urandom_range(40, 160);
            repeat (n) begin
                if (sw_phase == PH_IDLE && $urandom_range(0, 9) < 8) begin
                    // start of a sweep, low targets favoured
                    if (!fast)
                        lvl = LEVEL_W'($urandom_range(1, 2));
                    else if ($urandom_range(0, 3) == 0)
                        lvl = LEVEL_W'($urandom_range(4, MAX_LEVEL));
                    else
                        lvl = LEVEL_W'($urandom_range(1, 3));
                    send_item(REQ_CMD, lvl);
                end else if ($urandom_range(0, 19) == 0) begin
                    send_item(REQ_CMD, LEVEL_W'($urandom_range(0, 255)));
                end else begin
                    send_item(REQ_TICK, LEVEL_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // result side back-pressure in random bursts
    initial begin : result_stalls
        int stall;
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (out_gaps && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 12);
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk) begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pwm.size() == 0) begin
                $display("%0t: unexpected result item: pin %0b busy %0b angle %0d",
                         $time, pin_level, busy_res, angle_now);
                errors++;
            end else begin
                want = pending_pwm.pop_front();
                if (pin_level !== want.pin_level) begin
                    $display("%0t: pin_level expected %0b, got %0b",
                             $time, want.pin_level, pin_level);
                    errors++;
                end
                if (busy_res !== want.busy_res) begin
                    $display("%0t: busy_res expected %0b, got %0b",
                             $time, want.busy_res, busy_res);
                    errors++;
                end
                if (angle_now !== want.angle_now) begin
                    $display("%0t: angle_now expected %0d, got %0d",
                             $time, want.angle_now, angle_now);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // reset, tests in turn, then the final drain
    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req_type  = REQ_TICK;
        level     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ignored_commands();
        test_period_shrink();
        test_register_extremes();
        test_zero_period();
        test_random_sweeps();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
